// ===== src/cdfe_pkg.sv =====
package cdfe_pkg;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SCALED_RANGE = 2'd0;
    localparam logic [1:0] REG_FULL_RANGE   = 2'd1;
    localparam logic [1:0] REG_RAMP_STEP    = 2'd2;
    localparam logic [1:0] REG_WARM_MASK    = 2'd3;

    // Color temperature and mixing constants.
    localparam int CT_MIN      = 153;
    localparam int CT_MAX      = 500;
    localparam int CT_SPAN     = 347;
    localparam int SHARE_DIV   = 136;
    localparam int SHARE_MAX   = 255;
    localparam int SNAP_MARGIN = 50;
    localparam int PCT         = 100;

    // Reciprocals for division by 136 and by 100; the product is floor or floor - 1.
    localparam logic [14:0] RECIP_136    = 15'd30840;
    localparam int          RECIP_136_SH = 22;
    localparam logic [19:0] RECIP_100    = 20'd671088;
    localparam int          RECIP_100_SH = 26;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_SET_OFF,
        OP_SET_ON,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TARGET,
        BK_RAMP,
        BK_EMIT
    } t_back_state;

    // Classified command word. bri is already forced into 1..100 and
    // mired is the color temperature offset 0..347.
    typedef struct packed {
        t_op        op;
        logic [1:0] ch;
        logic       has_warm;
        logic [6:0] bri;
        logic [8:0] mired;
        logic       fast;
    } t_item;

    typedef struct packed {
        logic [11:0] scaled_range;
        logic [11:0] full_range;
        logic [11:0] ramp_step;
        logic [3:0]  warm_mask;
    } t_cfg;

    typedef struct packed {
        logic       start;
        logic       has_warm;
        logic [6:0] bri;
        logic [8:0] mired;
    } t_tgt_req;

    typedef struct packed {
        logic        done;
        logic [11:0] cold;
        logic [11:0] warm;
    } t_tgt_rsp;

endpackage

// ===== src/cct_dimmer_fade_engine.sv =====
// Dimmer fade engine for NUM_CHANNELS channels driving 2*NUM_CHANNELS duty slots.
// The slave stream carries commands: tuser low sets the targets of one channel
// (off, or on with brightness and color temperature), tuser high is a fade tick.
// A set produces no output. A tick steps every slot toward its target and sends
// one word per slot, in slot order, with tlast on the final slot; each word
// carries the slot, its new duty and whether all slots now sit on target.
// Configuration writes go through the plain write port; the user must make them
// only while the block is idle; the block itself does not enforce it. A set-off
// is applied when popped; a set-on waits for the seven-stage target multiply unit.
// A tick makes one pass over the slots through the single ramp unit, then one
// pass into the output register, one slot a cycle while the receiver takes them.
// Commands pass through an input register and a two-word queue, so up to three
// words are taken while the engine is still busy.
// Reset clears all duties, all targets and the pending fast flag, and loads
// the default configuration. If the receiver stalls, the output word holds
// and the output pass waits; the front keeps accepting until the queue fills.
module cct_dimmer_fade_engine #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [11:0]                    i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // channel[1:0], on[2], brightness[9:3], mired[18:10], fast[19], zero[23:20]
    input  logic [cdfe_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func: 0 set targets, 1 fade tick
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // slot[2:0], duty[14:3], settled[15]
    output logic [cdfe_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);
    import cdfe_pkg::*;

    t_cfg     r_cfg;
    logic     w_push;
    t_item    w_front_item;
    logic     w_full;
    logic     w_pop;
    logic     w_empty;
    t_item    w_queue_item;
    t_tgt_req w_req;
    t_tgt_rsp w_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scaled_range <= 12'd4095;
            r_cfg.full_range   <= 12'd4095;
            r_cfg.ramp_step    <= 12'd8;
            r_cfg.warm_mask    <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCALED_RANGE: r_cfg.scaled_range <= i_cfg_data;
                REG_FULL_RANGE:   r_cfg.full_range   <= i_cfg_data;
                REG_RAMP_STEP:    r_cfg.ramp_step    <= i_cfg_data;
                REG_WARM_MASK:    r_cfg.warm_mask    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    cdfe_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_warm_mask (r_cfg.warm_mask),
        .o_push      (w_push),
        .o_item      (w_front_item),
        .i_full      (w_full)
    );

    cdfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    cdfe_target u_target (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_scaled_range (r_cfg.scaled_range),
        .i_full_range   (r_cfg.full_range),
        .o_rsp          (w_rsp)
    );

    cdfe_back #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_item      (w_queue_item),
        .o_pop       (w_pop),
        .i_ramp_step (r_cfg.ramp_step),
        .o_req       (w_req),
        .i_rsp       (w_rsp),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ===== src/cdfe_front.sv =====
module cdfe_front #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [cdfe_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic [3:0]                       i_warm_mask,
    output logic                             o_push,
    output cdfe_pkg::t_item                  o_item,
    input  logic                             i_full
);
    import cdfe_pkg::*;

    logic [1:0] w_ch;
    logic       w_on;
    logic [6:0] w_bri;
    logic [8:0] w_ct;
    logic       w_fast;
    t_item      n_item;
    t_item      r_item;
    logic       r_valid;

    assign w_ch   = i_s_tdata[1:0];
    assign w_on   = i_s_tdata[2];
    assign w_bri  = i_s_tdata[9:3];
    assign w_ct   = i_s_tdata[18:10];
    assign w_fast = i_s_tdata[19];

    always_comb begin
        n_item.ch       = w_ch;
        n_item.fast     = w_fast;
        n_item.has_warm = i_warm_mask[w_ch];
        if (w_bri == 7'd0 || w_bri > 7'(PCT)) begin
            n_item.bri = 7'(PCT);
        end else begin
            n_item.bri = w_bri;
        end
        if (w_ct < 9'(CT_MIN)) begin
            n_item.mired = 9'd0;
        end else if (w_ct > 9'(CT_MAX)) begin
            n_item.mired = 9'(CT_SPAN);
        end else begin
            n_item.mired = w_ct - 9'(CT_MIN);
        end
        if (i_s_tuser) begin
            n_item.op = OP_TICK;
        end else if (4'(w_ch) >= 4'(NUM_CHANNELS)) begin
            n_item.op = OP_NOP;
        end else if (w_on) begin
            n_item.op = OP_SET_ON;
        end else begin
            n_item.op = OP_SET_OFF;
        end
    end

    assign o_s_tready = !r_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_valid;
    assign o_item = r_item;

endmodule

// ===== src/cdfe_queue.sv =====
module cdfe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cdfe_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cdfe_pkg::t_item o_item
);
    import cdfe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = r_count == (PTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty   = r_count == '0;
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_item    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== src/cdfe_target.sv =====
module cdfe_target (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdfe_pkg::t_tgt_req i_req,
    input  logic [11:0]        i_scaled_range,
    input  logic [11:0]        i_full_range,
    output cdfe_pkg::t_tgt_rsp o_rsp
);
    import cdfe_pkg::*;

    // floor(x / 255) for 12-bit x.
    function automatic logic [4:0] div255(input logic [11:0] x);
        logic [12:0] s;
        s = 13'(x) + 13'(x[11:8]) + 13'd1;
        return s[12:8];
    endfunction

    function automatic logic [7:0] share_est(input logic [15:0] v);
        logic [30:0] p;
        p = 31'(v) * 31'(RECIP_136);
        return 8'(p >> RECIP_136_SH);
    endfunction

    function automatic logic [7:0] share_fix(input logic [15:0] v, input logic [7:0] est);
        logic [15:0] rem;
        rem = v - 16'(est) * 16'(SHARE_DIV);
        return (rem >= 16'(SHARE_DIV)) ? est + 8'd1 : est;
    endfunction

    function automatic logic [11:0] pct_est(input logic [18:0] v);
        logic [38:0] p;
        p = 39'(v) * 39'(RECIP_100);
        return 12'(p >> RECIP_100_SH);
    endfunction

    function automatic logic [11:0] pct_fix(input logic [18:0] v, input logic [11:0] est,
                                            input logic snap_en, input logic [11:0] full);
        logic [18:0] rem;
        logic [11:0] t;
        rem = v - 19'(est) * 19'(PCT);
        t = (rem >= 19'(PCT)) ? est + 12'd1 : est;
        // Near-full values jump to full scale.
        if (snap_en && (13'(t) + 13'(SNAP_MARGIN) > 13'(full))) begin
            t = full;
        end
        return t;
    endfunction

    logic [6:0]  r_stage;
    logic [6:0]  r_bri;
    logic        r_warm;
    logic [4:0]  r_q;
    logic [15:0] r_vc;
    logic [15:0] r_vw;
    logic [7:0]  r_ac;
    logic [7:0]  r_aw;
    logic [7:0]  r_ic;
    logic [7:0]  r_iw;
    logic [14:0] r_pc;
    logic [14:0] r_pw;
    logic [18:0] r_sc;
    logic [18:0] r_sw;
    logic [11:0] r_dc;
    logic [11:0] r_dw;
    logic [11:0] r_tc;
    logic [11:0] r_tw;
    logic        w_snap;

    assign w_snap = r_warm && (r_bri == 7'(PCT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[5:0], i_req.start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_bri  <= i_req.bri;
            r_warm <= i_req.has_warm;
            r_q    <= div255(i_scaled_range);
            r_vc   <= 16'(9'(CT_SPAN) - i_req.mired) * 16'(PCT);
            r_vw   <= 16'(i_req.mired) * 16'(PCT);
        end
        if (r_stage[0]) begin
            r_ac <= share_est(r_vc);
            r_aw <= share_est(r_vw);
        end
        if (r_stage[1]) begin
            r_ic <= r_warm ? share_fix(r_vc, r_ac) : 8'(SHARE_MAX);
            r_iw <= share_fix(r_vw, r_aw);
        end
        if (r_stage[2]) begin
            r_pc <= 15'(r_ic) * 15'(r_bri);
            r_pw <= 15'(r_iw) * 15'(r_bri);
        end
        if (r_stage[3]) begin
            r_sc <= 19'(r_pc) * 19'(r_q);
            r_sw <= 19'(r_pw) * 19'(r_q);
        end
        if (r_stage[4]) begin
            r_dc <= pct_est(r_sc);
            r_dw <= pct_est(r_sw);
        end
        if (r_stage[5]) begin
            r_tc <= pct_fix(r_sc, r_dc, w_snap, i_full_range);
            r_tw <= pct_fix(r_sw, r_dw, w_snap, i_full_range);
        end
    end

    assign o_rsp.done = r_stage[6];
    assign o_rsp.cold = r_tc;
    assign o_rsp.warm = r_tw;

endmodule

// ===== src/cdfe_back.sv =====
module cdfe_back #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  cdfe_pkg::t_item                i_item,
    output logic                           o_pop,
    input  logic [11:0]                    i_ramp_step,
    output cdfe_pkg::t_tgt_req             o_req,
    input  cdfe_pkg::t_tgt_rsp             i_rsp,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [cdfe_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);
    import cdfe_pkg::*;

    localparam int NUM_SLOTS = 2 * NUM_CHANNELS;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    function automatic logic [11:0] ramp_duty(input logic [11:0] cur, input logic [11:0] tgt,
                                              input logic [11:0] step, input logic jump);
        logic [12:0] up;
        logic [12:0] dec;
        logic [12:0] down;
        logic [11:0] res;
        up   = 13'(cur) + 13'(step);
        dec  = (tgt == 12'd0) ? {step, 1'b0} : 13'(step);
        down = 13'(cur) - dec;
        if (cur < tgt) begin
            res = (up > 13'(tgt)) ? tgt : up[11:0];
        end else if (cur > tgt) begin
            // Falling under the step goes straight to zero, even below a nonzero target.
            if (13'(cur) < dec) begin
                res = 12'd0;
            end else if (down < 13'(tgt)) begin
                res = tgt;
            end else begin
                res = down[11:0];
            end
        end else begin
            res = cur;
        end
        if (jump) begin
            res = tgt;
        end
        return res;
    endfunction

    t_back_state       r_state;
    t_back_state       n_state;
    t_item             r_item;
    logic [SLOT_W-1:0] r_idx;
    logic              r_fast;
    logic              r_settled;
    logic [11:0]       r_cur [NUM_SLOTS];
    logic [11:0]       r_tgt [NUM_SLOTS];
    logic              r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic [11:0]       w_cur;
    logic [11:0]       w_tgt;
    logic [11:0]       w_new;
    logic              w_out_load;
    logic              w_last_idx;
    logic [SLOT_W-1:0] w_next_idx;
    logic [SLOT_W-1:0] w_pop_cold;
    logic [SLOT_W-1:0] w_pop_warm;
    logic [SLOT_W-1:0] w_set_cold;
    logic [SLOT_W-1:0] w_set_warm;

    assign w_cur      = r_cur[r_idx];
    assign w_tgt      = r_tgt[r_idx];
    assign w_new      = ramp_duty(w_cur, w_tgt, i_ramp_step, r_fast);
    assign w_last_idx = r_idx == LAST_SLOT;
    assign w_next_idx = w_last_idx ? '0 : r_idx + 1'b1;
    assign w_out_load = (r_state == BK_EMIT) && (!r_out_valid || i_m_tready);

    assign w_pop_cold = SLOT_W'(i_item.ch);
    assign w_pop_warm = LAST_SLOT - w_pop_cold;
    assign w_set_cold = SLOT_W'(r_item.ch);
    assign w_set_warm = LAST_SLOT - w_set_cold;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    if (i_item.op == OP_SET_ON) begin
                        n_state = BK_TARGET;
                    end else if (i_item.op == OP_TICK) begin
                        n_state = BK_RAMP;
                    end
                end
            end
            BK_TARGET: begin
                if (i_rsp.done) begin
                    n_state = BK_IDLE;
                end
            end
            BK_RAMP: begin
                if (w_last_idx) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_out_load && w_last_idx) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = (r_state == BK_IDLE) && !i_empty;
        o_req.start    = o_pop && (i_item.op == OP_SET_ON);
        o_req.has_warm = i_item.has_warm;
        o_req.bri      = i_item.bri;
        o_req.mired    = i_item.mired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_fast      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            // A fast request on any word takes effect at the next tick, this one included.
            if (o_pop && i_item.fast) begin
                r_fast <= 1'b1;
            end else if (r_state == BK_RAMP && w_last_idx) begin
                r_fast <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_RAMP) begin
                r_cur[r_idx] <= w_new;
            end
            if (o_pop && i_item.op == OP_SET_OFF) begin
                r_tgt[w_pop_cold] <= '0;
                if (i_item.has_warm) begin
                    r_tgt[w_pop_warm] <= '0;
                end
            end else if (r_state == BK_TARGET && i_rsp.done) begin
                r_tgt[w_set_cold] <= i_rsp.cold;
                if (r_item.has_warm) begin
                    r_tgt[w_set_warm] <= i_rsp.warm;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item    <= i_item;
            r_idx     <= '0;
            r_settled <= 1'b1;
        end else if (r_state == BK_RAMP) begin
            r_idx     <= w_next_idx;
            r_settled <= r_settled && (w_new == w_tgt);
        end else if (w_out_load) begin
            r_idx <= w_next_idx;
        end
        if (w_out_load) begin
            r_out_data <= {r_settled, w_cur, 3'(r_idx)};
            r_out_last <= w_last_idx;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== src/cdfe_checker.sv =====
module cdfe_checker #(
    parameter int NUM_CHANNELS = 4
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [cdfe_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);
    import cdfe_pkg::*;

    localparam logic [2:0] LAST_SLOT3 = 3'(2 * NUM_CHANNELS - 1);

    // A stalled word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // Within a tick the slots follow back to back and share one settled flag.
    a_slot_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tvalid && o_m_tdata[2:0] == $past(o_m_tdata[2:0]) + 3'd1
            && o_m_tdata[15] == $past(o_m_tdata[15]))
        else $error("tick words out of sequence");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[2:0] == LAST_SLOT3)
        else $error("tlast on a slot other than the final one");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast |=> !o_m_tvalid)
        else $error("output word right after the final slot");

endmodule

bind cct_dimmer_fade_engine cdfe_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_cdfe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/tb_cct_dimmer_fade_engine.sv =====
`timescale 1ns / 100ps

module tb_cct_dimmer_fade_engine;
    import cdfe_pkg::*;

    localparam int NUM_CH       = 4;
    localparam int NSLOT        = 2 * NUM_CH;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 60;
    localparam int NUM_PHASES   = 5;

    typedef enum logic {
        FN_SET  = 1'b0,
        FN_TICK = 1'b1
    } t_dim_func;

    typedef struct packed {
        t_dim_func  func;
        logic [1:0] ch;
        logic       on;
        logic [6:0] bri;
        logic [8:0] ct;
        logic       fast;
    } t_dim_cmd;

    typedef struct packed {
        logic [2:0]  slot;
        logic [11:0] duty;
        logic        settled;
        logic        last;
    } t_slot_report;

    // A tick row with pinned set carries its own expected duties, slot i at duties[i].
    typedef struct packed {
        t_dim_cmd                    cmd;
        logic                        pinned;
        logic [NSLOT-1:0][11:0]      duties;
        logic                        settled;
    } t_script_row;

    typedef struct packed {
        logic [11:0] scaled;
        logic [11:0] full;
        logic [11:0] ramp;
        logic [3:0]  warm;
    } t_fade_cfg;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [1:0]           i_cfg_idx  = REG_SCALED_RANGE;
    logic [11:0]          i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tuser  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;

    // Fade model state and its copy of the registers.
    logic [11:0] duty_now  [NSLOT] = '{default: '0};
    logic [11:0] duty_goal [NSLOT] = '{default: '0};
    bit          jump_pending = 1'b0;
    logic [11:0] cfg_scaled = 12'd4095;
    logic [11:0] cfg_full   = 12'd4095;
    logic [11:0] cfg_ramp   = 12'd8;
    logic [3:0]  cfg_warm   = 4'd0;

    t_slot_report pending_reports [$];
    int           mismatch_cnt = 0;
    int           cycle_cnt    = 0;
    logic         quiet        = 1'b0;
    logic         hold_req     = 1'b0;
    int           hold_left    = HOLD_CYCLES;

    cct_dimmer_fade_engine #(
        .NUM_CHANNELS(NUM_CH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clip12(int unsigned v);
        return (v > 4095) ? 4095 : v;
    endfunction

    function automatic int unsigned snap_to_full(int unsigned t);
        if (int'(t) > int'(cfg_full) - SNAP_MARGIN) begin
            return cfg_full;
        end
        return t;
    endfunction

    function automatic void set_goal(t_dim_cmd c);
        int unsigned b, q, ct, m, share_c, share_w, tc, tw;
        int          wslot;
        logic        warm;
        wslot = NSLOT - 1 - c.ch;
        warm  = cfg_warm[c.ch];
        if (!c.on) begin
            duty_goal[c.ch] = '0;
            if (warm) begin
                duty_goal[wslot] = '0;
            end
            return;
        end
        b = c.bri;
        if (b == 0 || b > PCT) begin
            b = PCT;
        end
        q = cfg_scaled / SHARE_MAX;
        if (warm) begin
            ct = c.ct;
            if (ct < CT_MIN) ct = CT_MIN;
            if (ct > CT_MAX) ct = CT_MAX;
            m       = ct - CT_MIN;
            share_c = (PCT * (CT_SPAN - m)) / SHARE_DIV;
            share_w = (PCT * m) / SHARE_DIV;
            tc = clip12((share_c * b * q) / PCT);
            tw = clip12((share_w * b * q) / PCT);
            // Full brightness pulls values near the top onto full scale.
            if (b == PCT) begin
                tc = snap_to_full(tc);
                tw = snap_to_full(tw);
            end
            duty_goal[c.ch]  = tc[11:0];
            duty_goal[wslot] = tw[11:0];
        end else begin
            tc = clip12((SHARE_MAX * b * q) / PCT);
            duty_goal[c.ch] = tc[11:0];
        end
    endfunction

    function automatic void fade_model_accept(t_script_row row);
        int unsigned  cur, tgt, d, up;
        bit           all_on;
        t_slot_report r;
        if (row.cmd.fast) begin
            jump_pending = 1'b1;
        end
        if (row.cmd.func == FN_SET) begin
            set_goal(row.cmd);
            return;
        end
        for (int i = 0; i < NSLOT; i++) begin
            cur = duty_now[i];
            tgt = duty_goal[i];
            if (cur < tgt) begin
                up  = cur + cfg_ramp;
                cur = (up > tgt) ? tgt : up;
            end else if (cur > tgt) begin
                // Fading to off runs at twice the step; an undershoot lands on zero.
                d = (tgt == 0) ? 2 * cfg_ramp : cfg_ramp;
                if (cur < d) begin
                    cur = 0;
                end else begin
                    cur = (cur - d < tgt) ? tgt : cur - d;
                end
            end
            if (jump_pending) begin
                cur = tgt;
            end
            duty_now[i] = cur[11:0];
        end
        jump_pending = 1'b0;
        all_on = 1'b1;
        for (int i = 0; i < NSLOT; i++) begin
            if (duty_now[i] != duty_goal[i]) all_on = 1'b0;
        end
        for (int i = 0; i < NSLOT; i++) begin
            r.slot    = i[2:0];
            r.duty    = row.pinned ? row.duties[i] : duty_now[i];
            r.settled = row.pinned ? row.settled : all_on;
            r.last    = (i == NSLOT - 1);
            pending_reports.push_back(r);
        end
    endfunction

    function automatic t_script_row set_row(logic [1:0] ch, logic on, logic [6:0] bri,
                                            logic [8:0] ct, logic fast);
        t_script_row r;
        r = '0;
        r.cmd.func = FN_SET;
        r.cmd.ch   = ch;
        r.cmd.on   = on;
        r.cmd.bri  = bri;
        r.cmd.ct   = ct;
        r.cmd.fast = fast;
        return r;
    endfunction

    function automatic t_script_row tick_row(logic fast, logic pinned,
                                             logic [NSLOT-1:0][11:0] duties, logic settled);
        t_script_row r;
        r = '0;
        r.cmd.func = FN_TICK;
        r.cmd.fast = fast;
        r.pinned   = pinned;
        r.duties   = duties;
        r.settled  = settled;
        return r;
    endfunction

    function automatic t_script_row random_row();
        t_script_row r;
        r = '0;
        r.cmd.func = ($urandom_range(99) < 60) ? FN_TICK : FN_SET;
        r.cmd.ch   = 2'($urandom_range(3));
        r.cmd.on   = ($urandom_range(3) != 0);
        case ($urandom_range(9))
            0:       r.cmd.bri = 7'd100;
            1, 2:    r.cmd.bri = 7'($urandom_range(127));
            default: r.cmd.bri = 7'($urandom_range(1, 100));
        endcase
        r.cmd.ct   = ($urandom_range(4) == 0) ? 9'($urandom_range(511))
                                              : 9'($urandom_range(CT_MIN, CT_MAX));
        r.cmd.fast = ($urandom_range(11) == 0);
        return r;
    endfunction

    function automatic void flag_mismatch(string what, t_slot_report want, t_slot_report got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $write("%0t %s: expected slot %0d duty %0d settled %0b last %0b",
                   $time, what, want.slot, want.duty, want.settled, want.last);
            $display(", got slot %0d duty %0d settled %0b last %0b",
                     got.slot, got.duty, got.settled, got.last);
        end
    endfunction

    task automatic send_word(t_script_row row);
        while (!quiet && $urandom_range(99) < 20) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tdata  <= {4'd0, row.cmd.fast, row.cmd.ct, row.cmd.bri, row.cmd.on, row.cmd.ch};
        i_s_tuser  <= row.cmd.func;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        fade_model_accept(row);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_SCALED_RANGE: cfg_scaled = val;
            REG_FULL_RANGE:   cfg_full   = val;
            REG_RAMP_STEP:    cfg_ramp   = val;
            REG_WARM_MASK:    cfg_warm   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(t_fade_cfg c);
        write_reg(REG_SCALED_RANGE, c.scaled);
        write_reg(REG_FULL_RANGE, c.full);
        write_reg(REG_RAMP_STEP, c.ramp);
        write_reg(REG_WARM_MASK, {8'd0, c.warm});
        i_cfg_we <= 1'b0;
    endtask

    // Stop offering words, let every expected word arrive, then give the
    // block time to finish sets that are still queued.
    task automatic wait_for_reports();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_req && hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (quiet) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin : check_words
        t_slot_report got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.slot    = o_m_tdata[2:0];
            got.duty    = o_m_tdata[14:3];
            got.settled = o_m_tdata[15];
            got.last    = o_m_tlast;
            if (pending_reports.size() == 0) begin
                flag_mismatch("unexpected word", '0, got);
            end else begin
                want = pending_reports.pop_front();
                if (got.slot !== want.slot || got.duty !== want.duty ||
                    got.settled !== want.settled || got.last !== want.last) begin
                    flag_mismatch("word mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** cct_dimmer_fade_engine: FAILED **");
            $finish;
        end
    end

    initial begin
        t_script_row script [$];
        t_fade_cfg   plan [NUM_PHASES];

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Channels 0 and 2 get a warm slot; everything else stays at reset values.
        program_regs('{12'd4095, 12'd4095, 12'd8, 4'b0101});

        script.push_back(tick_row(1'b0, 1'b1, '0, 1'b1));
        script.push_back(set_row(2'd0, 1'b1, 7'd100, 9'd153, 1'b0));
        script.push_back(set_row(2'd1, 1'b1, 7'd0, 9'd0, 1'b0));
        script.push_back(set_row(2'd2, 1'b1, 7'd127, 9'd511, 1'b0));
        script.push_back(set_row(2'd3, 1'b0, 7'd0, 9'd0, 1'b0));
        script.push_back(tick_row(1'b1, 1'b1,
                                  {12'd0, 12'd0, 12'd4095, 12'd0,
                                   12'd0, 12'd0, 12'd4080, 12'd4095}, 1'b1));
        script.push_back(set_row(2'd0, 1'b0, 7'd55, 9'd200, 1'b0));
        script.push_back(tick_row(1'b0, 1'b0, '0, 1'b0));
        script.push_back(set_row(2'd1, 1'b1, 7'd1, 9'd300, 1'b0));
        script.push_back(tick_row(1'b0, 1'b0, '0, 1'b0));
        script.push_back(set_row(2'd2, 1'b1, 7'd50, 9'd326, 1'b0));
        script.push_back(set_row(2'd3, 1'b1, 7'd100, 9'd153, 1'b0));
        script.push_back(tick_row(1'b0, 1'b0, '0, 1'b0));
        script.push_back(tick_row(1'b0, 1'b0, '0, 1'b0));
        script.push_back(set_row(2'd0, 1'b1, 7'd75, 9'd400, 1'b1));
        script.push_back(tick_row(1'b0, 1'b0, '0, 1'b0));
        script.push_back(set_row(2'd3, 1'b1, 7'd100, 9'd500, 1'b0));
        script.push_back(set_row(2'd1, 1'b0, 7'd127, 9'd511, 1'b1));
        script.push_back(tick_row(1'b1, 1'b0, '0, 1'b0));
        script.push_back(set_row(2'd2, 1'b1, 7'd100, 9'd153, 1'b0));
        script.push_back(tick_row(1'b0, 1'b0, '0, 1'b0));
        script.push_back(tick_row(1'b0, 1'b0, '0, 1'b0));
        foreach (script[i]) begin
            send_word(script[i]);
        end
        wait_for_reports();

        plan[0] = '{12'd4095, 12'd4095, 12'd1, 4'hF};
        plan[1] = '{12'd0, 12'd1, 12'd4095, 4'hA};
        plan[2] = '{12'($urandom_range(4095)), 12'($urandom_range(1, 4095)),
                    12'($urandom_range(1, 64)), 4'($urandom_range(15))};
        // A zero step freezes the duties until a fast tick.
        plan[3] = '{12'd2550, 12'd2600, 12'd0, 4'h5};
        plan[4] = '{12'($urandom_range(4095)), 12'($urandom_range(1, 4095)),
                    12'($urandom_range(1, 4095)), 4'($urandom_range(15))};

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_regs(plan[p]);
            quiet <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_word(random_row());
            end
            if (p == NUM_PHASES - 1) begin
                // Receiver stalls for a long stretch while ticks keep coming.
                hold_req <= 1'b1;
                for (int n = 0; n < 30; n++) begin
                    send_word(tick_row(1'b0, 1'b0, '0, 1'b0));
                end
            end
            wait_for_reports();
        end

        if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
            $display("** cct_dimmer_fade_engine: PASSED **");
        end else begin
            $display("** cct_dimmer_fade_engine: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cdfe_pkg.sv
src/cdfe_front.sv
src/cdfe_queue.sv
src/cdfe_target.sv
src/cdfe_back.sv
src/cct_dimmer_fade_engine.sv
src/cdfe_checker.sv
tb/tb_cct_dimmer_fade_engine.sv
